// ===== design/pli_pkg.sv =====
// shared types and constants for the polyline inverse interpolator
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic REG_Y_OFFSET = 1'b0;

	localparam int LAST_VALID_INDEX = 30;

	localparam int DIFF_W = 19;
	localparam int MAG_W  = 18;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} pli_point_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] num;
		logic signed [DIFF_W-1:0] den;
	} pli_frac_req_t;

endpackage

`default_nettype wire

// ===== design/pli_mem.sv =====
// point table memory, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module pli_mem
	import pli_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire pli_point_t    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output pli_point_t         rd_data
);

	pli_point_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== design/pli_frac.sv =====
// iterative fraction unit, one quotient bit per cycle, clamped to 1.0
`timescale 1ns / 1ps
`default_nettype none

module pli_frac
	import pli_pkg::*;
#(
	parameter int FRAC_BITS = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire pli_frac_req_t  req,
	output logic                done,
	output logic [FRAC_BITS:0]  t
);

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [MAG_W-1:0]  num_mag;
	logic [MAG_W-1:0]  den_mag;
	logic              skip;
	logic              sat;
	logic [MAG_W:0]    rem2;
	logic              take;
	logic [MAG_W-1:0]  rem_q;
	logic [MAG_W-1:0]  den_q;
	logic [FRAC_BITS:0] quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	always_comb begin
		num_mag = req.num[DIFF_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
		den_mag = req.den[DIFF_W-1] ? MAG_W'(-req.den) : MAG_W'(req.den);
		skip    = (req.num == '0) || (req.den == '0) || (req.num[DIFF_W-1] != req.den[DIFF_W-1]);
		sat     = num_mag >= den_mag;
		rem2    = {rem_q, 1'b0};
		take    = rem2 >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (req.start && (skip || sat)) ||
				(!req.start && busy_q && (cnt_q == CW'(1)));
			if (req.start) begin
				if (!(skip || sat)) begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= num_mag;
			den_q <= den_mag;
			if (skip) begin
				quo_q <= '0;
			end else if (sat) begin
				quo_q <= (FRAC_BITS + 1)'(1) << FRAC_BITS;
			end else begin
				quo_q <= '0;
			end
		end else if (busy_q) begin
			if (take) begin
				rem_q <= MAG_W'(rem2 - {1'b0, den_q});
			end else begin
				rem_q <= MAG_W'(rem2);
			end
			quo_q <= {quo_q[FRAC_BITS-1:0], take};
		end
	end

	assign done = done_q;
	assign t    = quo_q;

endmodule

`default_nettype wire

// ===== design/polyline_inverse_interpolator.sv =====
// polyline inverse interpolator: table scan, fraction unit and interpolation
// write request: accepted while idle, no response
// query: a scan of one table entry per cycle until a hit, then ST_HIT, ST_DIV and ST_MUL,
// then ST_ROUND; a miss goes from the scan to ST_ROUND; the fraction unit is bit-serial
// one query in flight at a time; a finished response waits in the output register
// reset clears control and y_offset; table contents are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module polyline_inverse_interpolator
	import pli_pkg::*;
#(
	parameter int TABLE_DEPTH = 32,
	parameter int FRAC_BITS   = 12
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic               command,
	input  wire logic [4:0]         entry_index,
	input  wire logic signed [15:0] entry_x,
	input  wire logic signed [15:0] entry_y,
	input  wire logic signed [15:0] target_y,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output logic                    found,
	output logic signed [15:0]      x_result,
	output logic [4:0]              segment_index,
	output logic                    index_valid
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = FRAC_BITS + 19;
	localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_DIV,
		ST_MUL,
		ST_ROUND
	} state_t;

	state_t                  state_q;
	logic signed [15:0]      y_offset_q;
	logic [AW-1:0]           scan_idx_q;
	logic signed [15:0]      prev_x_q;
	logic signed [17:0]      prev_y_q;
	logic signed [15:0]      cur_x_q;
	logic signed [17:0]      cur_y_q;
	logic signed [15:0]      target_q;
	logic                    found_q;
	logic [FRAC_BITS:0]      t_q;
	logic signed [PW-1:0]    prod_q;
	logic                    res_valid_q;
	logic                    found_r_q;
	logic signed [15:0]      x_result_q;
	logic [4:0]              seg_q;
	logic                    index_valid_q;

	logic                    cfg_wr;
	logic                    req_acc;
	logic                    mem_wr;
	logic                    mem_rd;
	logic [AW-1:0]           mem_raddr;
	pli_point_t              wr_point;
	pli_point_t              rd_point;
	logic signed [17:0]      rd_y;
	logic signed [17:0]      target18;
	logic                    hit;
	logic                    last;
	logic                    out_free;
	pli_frac_req_t           frac_req;
	logic                    frac_done;
	logic [FRAC_BITS:0]      frac_t;
	logic signed [16:0]      dx;
	logic signed [FRAC_BITS+1:0] t_ext;
	logic signed [PW-1:0]    rnd;
	logic signed [15:0]      x_calc;
	logic                    idx_ok;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_Y_OFFSET);
	assign prdata    = (paddr[2] == REG_Y_OFFSET) ? {{16{y_offset_q[15]}}, y_offset_q} : '0;
	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;

	always_comb begin
		mem_wr     = req_acc && (command == CMD_WRITE) && (32'(entry_index) < TABLE_DEPTH);
		wr_point.x = entry_x;
		wr_point.y = entry_y;
		mem_rd     = (req_acc && (command == CMD_QUERY)) || (state_q == ST_SCAN);
		mem_raddr  = (state_q == ST_SCAN) ? AW'(scan_idx_q + 1'b1) : '0;
		rd_y       = 18'(rd_point.y) + 18'(y_offset_q);
		target18   = 18'(target_q);
		hit        = (scan_idx_q != '0) && (rd_y >= target18);
		last       = scan_idx_q == AW'(TABLE_DEPTH - 1);
		out_free   = !res_valid_q || res_ready;
		frac_req.start = (state_q == ST_HIT);
		frac_req.num   = DIFF_W'(target18) - DIFF_W'(prev_y_q);
		frac_req.den   = DIFF_W'(cur_y_q) - DIFF_W'(prev_y_q);
		dx     = 17'(cur_x_q) - 17'(prev_x_q);
		t_ext  = $signed({1'b0, t_q});
		rnd    = (prod_q + HALF) >>> FRAC_BITS;
		x_calc = prev_x_q + 16'(rnd);
		idx_ok = 32'(scan_idx_q) <= 32'(LAST_VALID_INDEX);
	end

	pli_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (AW'(entry_index)),
		.wr_data (wr_point),
		.rd_en   (mem_rd),
		.rd_addr (mem_raddr),
		.rd_data (rd_point)
	);

	pli_frac #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (frac_req),
		.done   (frac_done),
		.t      (frac_t)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_offset_q <= '0;
		end else if (cfg_wr) begin
			y_offset_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			scan_idx_q    <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			cur_x_q       <= '0;
			cur_y_q       <= '0;
			target_q      <= '0;
			found_q       <= 1'b0;
			t_q           <= '0;
			prod_q        <= '0;
			res_valid_q   <= 1'b0;
			found_r_q     <= 1'b0;
			x_result_q    <= '0;
			seg_q         <= '0;
			index_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && (state_q != ST_ROUND)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && (command == CMD_QUERY)) begin
						target_q   <= target_y;
						scan_idx_q <= '0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						cur_x_q <= rd_point.x;
						cur_y_q <= rd_y;
						found_q <= 1'b1;
						state_q <= ST_HIT;
					end else begin
						prev_x_q <= rd_point.x;
						prev_y_q <= rd_y;
						if (last) begin
							found_q <= 1'b0;
							state_q <= ST_ROUND;
						end else begin
							scan_idx_q <= AW'(scan_idx_q + 1'b1);
						end
					end
				end
				ST_HIT: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (frac_done) begin
						t_q     <= frac_t;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= PW'(dx) * PW'(t_ext);
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_free) begin
						res_valid_q   <= 1'b1;
						found_r_q     <= found_q;
						x_result_q    <= found_q ? x_calc : '0;
						seg_q         <= found_q ? 5'(scan_idx_q) : '0;
						index_valid_q <= found_q && idx_ok;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign found         = found_r_q;
	assign x_result      = x_result_q;
	assign segment_index = seg_q;
	assign index_valid   = index_valid_q;

endmodule

`default_nettype wire

// ===== design/pli_chk.sv =====
// port-level checker for the polyline inverse interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pli_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        command,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic        found,
	input wire logic [15:0] x_result,
	input wire logic [4:0]  segment_index,
	input wire logic        index_valid
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("response dropped before acceptance");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !command |=> !$rose(res_valid))
		else $error("response after a write request");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && command |=> !req_ready)
		else $error("new request taken while a query is in flight");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !found |-> x_result == '0 && segment_index == '0 && !index_valid)
		else $error("miss response carries nonzero fields");

	a_idx_found: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && index_valid |-> found && segment_index != 5'd31)
		else $error("index valid without a usable hit");

endmodule

bind polyline_inverse_interpolator pli_chk u_pli_chk (.*);

`default_nettype wire
